// File: hdl/sdt_pkg.sv
`default_nettype none

package sdt_pkg;

   localparam int COUNT_W     = 63;
   localparam int WAKE_W      = 64;
   localparam int THREAD_W    = 8;
   localparam int DUR_W       = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SLEEP = 1'b1;

   localparam logic [1:0] STATUS_SLEEP_OK = 2'd0;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_TICK     = 2'd3;

   typedef struct packed {
      logic                  op;
      logic [THREAD_W-1:0]   thread_id;
      logic signed [31:0]    sleep_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic                  wake_valid;
      logic [THREAD_W-1:0]   woken_thread;
      logic [COUNT_W-1:0]    now_ticks;
      logic                  last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SLEEP,
      CMD_IGNORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [THREAD_W-1:0]   thread_id;
      logic [DUR_W-1:0]      ticks;
   } cmd_type;

endpackage

`default_nettype wire

// File: hdl/sdt_front.sv
`default_nettype none

module sdt_front
   import sdt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_pop
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   cmd_type             new_cmd;
   logic                push;
   logic                pop;

   // classify the request before it is queued
   always_comb begin
      new_cmd.thread_id = req_data.thread_id;
      new_cmd.ticks     = req_data.sleep_ticks[DUR_W-1:0];
      if (req_data.op == OP_TICK) begin
         new_cmd.kind = CMD_TICK;
      end else if (req_data.sleep_ticks[31]) begin
         new_cmd.kind = CMD_IGNORE;
      end else begin
         new_cmd.kind = CMD_SLEEP;
      end
   end

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/sdt_back.sv
`default_nettype none

module sdt_back
   import sdt_pkg::*;
#(
   parameter  int SLOTS = 16,
   localparam int IDX_W = $clog2(SLOTS)
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [COUNT_W-1:0]    tick_count_ff;
   logic [SLOTS-1:0]      busy_ff;
   logic [IDX_W-1:0]      scan_idx_ff;
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [WAKE_W-1:0]     rd_wake_ff;
   logic [THREAD_W-1:0]   rd_thread_ff;
   logic                  pend_valid_ff;
   logic [THREAD_W-1:0]   pend_thread_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_data_ff;

   logic [WAKE_W-1:0]     wake_mem [SLOTS];
   logic [THREAD_W-1:0]   thread_mem [SLOTS];

   logic [SLOTS-1:0]      free;
   logic [SLOTS-1:0]      lowest;
   logic                  full;
   logic [IDX_W-1:0]      free_idx;
   logic                  wr_en;
   logic [WAKE_W-1:0]     wr_wake;
   logic                  hit;

   function automatic rsp_type make_rsp(input logic [1:0] status, input logic valid,
                                        input logic [THREAD_W-1:0] thread,
                                        input logic [COUNT_W-1:0] count, input logic last);
      rsp_type r;
      r.status       = status;
      r.wake_valid   = valid;
      r.woken_thread = thread;
      r.now_ticks    = count;
      r.last         = last;
      return r;
   endfunction

   // lowest free slot: isolate the lowest set bit, then encode it
   always_comb begin
      free     = ~busy_ff;
      lowest   = free & (~free + SLOTS'(1));
      full     = ~|free;
      free_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign wr_en   = cmd_pop && (cmd.kind == CMD_SLEEP) && !full;
   assign wr_wake = {1'b0, tick_count_ff} + {{(WAKE_W-DUR_W){1'b0}}, cmd.ticks};
   assign hit     = rd_valid_ff && busy_ff[rd_idx_ff]
                    && ({1'b0, tick_count_ff} >= rd_wake_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wake_mem[free_idx]   <= wr_wake;
         thread_mem[free_idx] <= cmd.thread_id;
      end
      rd_wake_ff   <= wake_mem[scan_idx_ff];
      rd_thread_ff <= thread_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_count_ff <= '0;
         busy_ff       <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;

         // a new hit pushes out the held one, which cannot be the final result
         if (hit) begin
            busy_ff[rd_idx_ff] <= 1'b0;
            pend_valid_ff      <= 1'b1;
            pend_thread_ff     <= rd_thread_ff;
            if (pend_valid_ff) begin
               rsp_strobe_ff <= 1'b1;
               rsp_data_ff   <= make_rsp(STATUS_TICK, 1'b1, pend_thread_ff,
                                         tick_count_ff, 1'b0);
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  unique case (cmd.kind)
                     CMD_SLEEP: begin
                        rsp_strobe_ff <= 1'b1;
                        if (full) begin
                           rsp_data_ff <= make_rsp(STATUS_FULL, 1'b0, '0,
                                                   tick_count_ff, 1'b1);
                        end else begin
                           busy_ff[free_idx] <= 1'b1;
                           rsp_data_ff <= make_rsp(STATUS_SLEEP_OK, 1'b0, '0,
                                                   tick_count_ff, 1'b1);
                        end
                     end
                     CMD_IGNORE: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_data_ff   <= make_rsp(STATUS_NEGATIVE, 1'b0, '0,
                                                  tick_count_ff, 1'b1);
                     end
                     CMD_TICK: begin
                        tick_count_ff <= tick_count_ff + COUNT_W'(1);
                        scan_idx_ff   <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= ST_SCAN;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               rd_valid_ff <= 1'b1;
               rd_idx_ff   <= scan_idx_ff;
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
               if (scan_idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // last slot is compared in this cycle
               rd_valid_ff <= 1'b0;
               state_ff    <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_strobe_ff <= 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_ff <= make_rsp(STATUS_TICK, 1'b1, pend_thread_ff,
                                          tick_count_ff, 1'b1);
               end else begin
                  rsp_data_ff <= make_rsp(STATUS_TICK, 1'b0, '0, tick_count_ff, 1'b1);
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/sleep_deadline_table.sv
`default_nettype none

// Alarm-clock sleep queue: keeps a 63-bit tick count and a table of SLOTS sleeping
// threads with absolute wake times. A transaction with op = 1 asks a thread to sleep
// for sleep_ticks ticks and gives one result (accepted, negative ignored, or table
// full); op = 0 is a timer tick that advances the count and gives one result per
// thread it wakes, in slot order, or one plain tick report if it wakes nobody; last
// marks the final result of each transaction. Requests are taken while busy is low
// into a two-entry command queue; each result is shown for one cycle on rsp_strobe
// and cannot be held off. A sleep request passes through the command queue and then
// the registered result; a tick passes through the command queue, then the scan of
// the wake-time memory, one slot per cycle through its single read port, then the
// compare of the last slot and the registered final report. No clearing pass is
// needed after reset.
module sleep_deadline_table
   import sdt_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   sdt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   sdt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // only tick results can be followed by more results of the same transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != STATUS_TICK) |-> rsp_data.last
                                                        && !rsp_data.wake_valid)
      else $error("non-tick result not final or names a thread");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.wake_valid |-> rsp_data.last)
      else $error("result without a woken thread is not final");

   assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

`default_nettype wire

// File: test/sdt_checker.sv
module sdt_checker
   import sdt_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   logic [COUNT_W-1:0]  now_count;
   logic                slot_used     [SLOTS];
   logic [THREAD_W-1:0] slot_owner    [SLOTS];
   logic [WAKE_W-1:0]   slot_deadline [SLOTS];
   rsp_type             wake_reports  [$];
   rsp_type             want;
   int                  errors = 0;

   function automatic rsp_type make_report(input logic [1:0] status, input logic valid,
                                           input logic [THREAD_W-1:0] thread,
                                           input logic last);
      rsp_type r;
      r.status       = status;
      r.wake_valid   = valid;
      r.woken_thread = thread;
      r.now_ticks    = now_count;
      r.last         = last;
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] exp_val,
                         input logic [63:0] got_val);
      $display("sdt mismatch on %0s: expected %0h, got %0h", what, exp_val, got_val);
      errors++;
   endtask

   // advances the sleep table by one accepted transaction and queues its reports
   task automatic advance_table(input req_type r);
      logic    placed;
      int      woken;
      rsp_type tail;
      if (r.op == OP_SLEEP) begin
         if (r.sleep_ticks[31]) begin
            wake_reports.push_back(make_report(STATUS_NEGATIVE, 1'b0, '0, 1'b1));
         end else begin
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && !slot_used[i]) begin
                  placed           = 1'b1;
                  slot_used[i]     = 1'b1;
                  slot_owner[i]    = r.thread_id;
                  slot_deadline[i] = {1'b0, now_count} + {33'b0, r.sleep_ticks[30:0]};
               end
            end
            wake_reports.push_back(make_report(placed ? STATUS_SLEEP_OK : STATUS_FULL,
                                               1'b0, '0, 1'b1));
         end
      end else begin
         now_count = now_count + COUNT_W'(1);
         woken = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && ({1'b0, now_count} >= slot_deadline[i])) begin
               slot_used[i] = 1'b0;
               wake_reports.push_back(make_report(STATUS_TICK, 1'b1, slot_owner[i], 1'b0));
               woken++;
            end
         end
         if (woken == 0) begin
            wake_reports.push_back(make_report(STATUS_TICK, 1'b0, '0, 1'b1));
         end else begin
            tail = wake_reports.pop_back();
            tail.last = 1'b1;
            wake_reports.push_back(tail);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         now_count = '0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]     = 1'b0;
            slot_owner[i]    = '0;
            slot_deadline[i] = '0;
         end
         wake_reports.delete();
      end else begin
         if (start && !busy) begin
            advance_table(req_data);
         end
         if (rsp_strobe) begin
            if (wake_reports.size() == 0) begin
               report("unexpected result status", '0, 64'(rsp_data.status));
            end else begin
               want = wake_reports.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 64'(want.status), 64'(rsp_data.status));
               if (rsp_data.wake_valid !== want.wake_valid)
                  report("wake_valid", 64'(want.wake_valid), 64'(rsp_data.wake_valid));
               if (rsp_data.woken_thread !== want.woken_thread)
                  report("woken_thread", 64'(want.woken_thread),
                         64'(rsp_data.woken_thread));
               if (rsp_data.now_ticks !== want.now_ticks)
                  report("now_ticks", 64'(want.now_ticks), 64'(rsp_data.now_ticks));
               if (rsp_data.last !== want.last)
                  report("last", 64'(want.last), 64'(rsp_data.last));
            end
         end
      end
      pending_count = wake_reports.size();
      fail_count    = errors;
   end

endmodule

// File: test/tb_top.sv
module tb_top;
   import sdt_pkg::*;

   localparam int SLOTS        = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 64;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   logic    calm;

   sleep_deadline_table #(.SLOTS(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   sdt_checker #(.SLOTS(SLOTS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type sleep_req(input logic [THREAD_W-1:0] tid,
                                         input logic [31:0] dur);
      req_type r;
      r.op          = OP_SLEEP;
      r.thread_id   = tid;
      r.sleep_ticks = dur;
      return r;
   endfunction

   // thread and duration fields are don't-care on a tick, so fill them with noise
   function automatic req_type tick_req();
      req_type r;
      r.op          = OP_TICK;
      r.thread_id   = THREAD_W'($urandom_range(255));
      r.sleep_ticks = $urandom;
      return r;
   endfunction

   function automatic logic [31:0] pick_duration();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return $urandom_range(24);
      else if (pick < 72)
         return $urandom | 32'h8000_0000;
      else if (pick < 80)
         return 32'd0;
      else if (pick < 97)
         return $urandom_range(60, 25);
      else
         return $urandom >> 1;
   endfunction

   task automatic issue(input req_type r);
      while (!calm && ($urandom_range(99) < 16)) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      calm     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // fill every slot with the same deadline, overflow once, then wake them all
      for (int k = 0; k < SLOTS; k++) begin
         issue(sleep_req(THREAD_W'(k * 17), 32'd1));
      end
      issue(sleep_req(8'hAA, 32'd5));
      issue(tick_req());
      // zero duration from the same thread twice
      issue(sleep_req(8'h42, 32'd0));
      issue(sleep_req(8'h42, 32'd0));
      issue(sleep_req(8'h01, 32'hFFFF_FFFF));
      issue(sleep_req(8'h02, 32'h8000_0000));
      issue(tick_req());
      issue(tick_req());
      issue(sleep_req(8'hFF, 32'h7FFF_FFFF));
      issue(sleep_req(8'h55, 32'd3));

      for (int k = 0; k < 204; k++) begin
         calm = (k >= 80) && (k < 130);
         if ($urandom_range(99) < 45)
            issue(tick_req());
         else
            issue(sleep_req(THREAD_W'($urandom_range(255)), pick_duration()));
      end
      calm = 1'b0;
      start <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if ((fail_count == 0) && (pending_count == 0))
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hdl/sdt_pkg.sv
hdl/sdt_front.sv
hdl/sdt_back.sv
hdl/sleep_deadline_table.sv
test/sdt_checker.sv
test/tb_top.sv
